// ===== rtl/core/tep_pkg.sv =====
// Shared constants, codes and control structures for the task event priority scheduler.
package tep_pkg;

   localparam int MAX_TASKS     = 16;
   localparam int PRIORITY_BITS = 8;

   localparam int OP_W       = 2;
   localparam int TID_W      = 4;
   localparam int FLAG_W     = 16;
   localparam int REQ_PRIO_W = 8;
   localparam int STATUS_W   = 2;

   localparam int ID_W      = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int COUNT_W   = $clog2(MAX_TASKS + 1);
   localparam int CMP_W     = (COUNT_W > TID_W) ? COUNT_W : TID_W;
   localparam int IDX_EXT_W = (ID_W > TID_W) ? ID_W : TID_W;
   localparam int PR_EXT_W  = (PRIORITY_BITS > REQ_PRIO_W) ? PRIORITY_BITS : REQ_PRIO_W;

   typedef enum logic [OP_W-1:0] {
      OP_REGISTER = 2'd0,
      OP_SET      = 2'd1,
      OP_CLEAR    = 2'd2,
      OP_QUERY    = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_INVALID = 2'd1,
      STAT_FULL    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_REG_WALK,
      S_REG_INS,
      S_EV_WRITE,
      S_Q_WALK,
      S_RESP
   } state_type;

   // One entry of the service order list: the task id and its priority.
   typedef struct packed {
      logic [PRIORITY_BITS-1:0] prio;
      logic [ID_W-1:0]          id;
   } order_entry_type;

   typedef struct packed {
      logic capture;
      logic reg_rd_last;
      logic reg_rd_prev;
      logic reg_shift;
      logic pos_zero;
      logic pos_next;
      logic insert;
      logic ev_rd_tid;
      logic ev_update;
      logic q_start;
      logic q_step;
      logic res_full;
      logic res_invalid;
      logic res_none;
      logic res_found;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   full;
      logic   count_zero;
      logic   tid_ok;
      logic   shift_ok;
      logic   walk_zero;
      logic   q_hit;
      logic   q_empty;
   } stat_type;

endpackage

// ===== rtl/core/tep_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module tep_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/tep_ctrl.sv =====
// Controller state machine that sequences register, set, clear and query transactions.
module tep_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  tep_pkg::stat_type stat,
   output tep_pkg::cmd_type  cmd
);
   import tep_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      out_free = !rsp_valid_ff || !rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.op)
               OP_REGISTER: begin
                  priority if (stat.full) begin
                     cmd.res_full = 1'b1;
                     state_in     = S_RESP;
                  end else if (stat.count_zero) begin
                     cmd.pos_zero = 1'b1;
                     state_in     = S_REG_INS;
                  end else begin
                     cmd.reg_rd_last = 1'b1;
                     state_in        = S_REG_WALK;
                  end
               end
               OP_SET, OP_CLEAR: begin
                  if (!stat.tid_ok) begin
                     cmd.res_invalid = 1'b1;
                     state_in        = S_RESP;
                  end else begin
                     cmd.ev_rd_tid = 1'b1;
                     state_in      = S_EV_WRITE;
                  end
               end
               OP_QUERY: begin
                  if (stat.count_zero) begin
                     cmd.res_none = 1'b1;
                     state_in     = S_RESP;
                  end else begin
                     cmd.q_start = 1'b1;
                     state_in    = S_Q_WALK;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_REG_WALK: begin
            if (stat.shift_ok) begin
               cmd.reg_shift = 1'b1;
               if (stat.walk_zero) begin
                  cmd.pos_zero = 1'b1;
                  state_in     = S_REG_INS;
               end else begin
                  cmd.reg_rd_prev = 1'b1;
               end
            end else begin
               cmd.pos_next = 1'b1;
               state_in     = S_REG_INS;
            end
         end
         S_REG_INS: begin
            cmd.insert = 1'b1;
            state_in   = S_RESP;
         end
         S_EV_WRITE: begin
            cmd.ev_update = 1'b1;
            state_in      = S_RESP;
         end
         S_Q_WALK: begin
            priority if (stat.q_hit) begin
               cmd.res_found = 1'b1;
               state_in      = S_RESP;
            end else if (stat.q_empty) begin
               cmd.res_none = 1'b1;
               state_in     = S_RESP;
            end else begin
               cmd.q_step = 1'b1;
            end
         end
         S_RESP: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/tep_dpath.sv =====
// Datapath with the order list and event RAMs, walk indexes and result registers.
module tep_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [tep_pkg::OP_W-1:0]         req_opcode,
   input  logic [tep_pkg::TID_W-1:0]        req_task_id,
   input  logic [tep_pkg::FLAG_W-1:0]       req_flags,
   input  logic [tep_pkg::REQ_PRIO_W-1:0]   req_priority_req,
   input  tep_pkg::cmd_type                 cmd,
   output tep_pkg::stat_type                stat,
   output logic [tep_pkg::STATUS_W-1:0]     rsp_status,
   output logic [tep_pkg::TID_W-1:0]        rsp_result_id,
   output logic                             rsp_found,
   output logic [tep_pkg::FLAG_W-1:0]       rsp_event_mask
);
   import tep_pkg::*;

   typedef struct packed {
      status_type        status;
      logic [TID_W-1:0]  id;
      logic              found;
      logic [FLAG_W-1:0] mask;
   } res_type;

   function automatic logic [TID_W-1:0] to_rsp_id(input logic [ID_W-1:0] id);
      logic [IDX_EXT_W-1:0] ext;
      ext = IDX_EXT_W'(id);
      return ext[TID_W-1:0];
   endfunction

   op_type                   op_ff;
   logic [TID_W-1:0]         tid_ff;
   logic [FLAG_W-1:0]        flags_ff;
   logic [PRIORITY_BITS-1:0] pr_ff;
   logic [COUNT_W-1:0]       count_ff;
   logic [ID_W-1:0]          walk_ff;
   logic [ID_W-1:0]          pos_ff;
   logic [COUNT_W-1:0]       next_ff;
   logic                     a_valid_ff;
   logic                     b_valid_ff;
   logic [ID_W-1:0]          hit_id_ff;
   res_type                  res_ff, res_in;
   res_type                  rsp_ff;

   logic [PR_EXT_W-1:0]      pr_ext;
   logic [CMP_W-1:0]         tid_ext;
   logic [ID_W-1:0]          tid_idx;
   logic [COUNT_W-1:0]       count_m1;
   logic [ID_W-1:0]          count_id;
   logic                     more;
   logic [FLAG_W-1:0]        new_mask;

   logic                     ord_wr_en, ord_rd_en;
   logic [ID_W-1:0]          ord_wr_addr, ord_rd_addr;
   order_entry_type          ord_wr_data, ord_rd_data;
   logic                     ev_wr_en, ev_rd_en;
   logic [ID_W-1:0]          ev_wr_addr, ev_rd_addr;
   logic [FLAG_W-1:0]        ev_wr_data, ev_rd_data;

   assign pr_ext   = PR_EXT_W'(req_priority_req);
   assign tid_ext  = CMP_W'(tid_ff);
   assign tid_idx  = tid_ext[ID_W-1:0];
   assign count_m1 = count_ff - COUNT_W'(1);
   assign count_id = count_ff[ID_W-1:0];
   assign more     = (next_ff < count_ff);
   assign new_mask = (op_ff == OP_SET) ? (ev_rd_data | flags_ff) : (ev_rd_data & ~flags_ff);

   always_comb begin
      stat.op         = op_ff;
      stat.full       = (count_ff == COUNT_W'(MAX_TASKS));
      stat.count_zero = (count_ff == '0);
      stat.tid_ok     = (tid_ext < CMP_W'(count_ff));
      stat.shift_ok   = (ord_rd_data.prio < pr_ff);
      stat.walk_zero  = (walk_ff == '0);
      stat.q_hit      = b_valid_ff && (ev_rd_data != '0);
      stat.q_empty    = !a_valid_ff && !b_valid_ff && !more;
   end

   // Order list port use: backward walk with shift on register, forward walk on query.
   always_comb begin
      ord_rd_en   = cmd.reg_rd_last || cmd.reg_rd_prev || cmd.q_start || (cmd.q_step && more);
      ord_rd_addr = next_ff[ID_W-1:0];
      if (cmd.reg_rd_last) begin
         ord_rd_addr = count_m1[ID_W-1:0];
      end else if (cmd.reg_rd_prev) begin
         ord_rd_addr = walk_ff - ID_W'(1);
      end else if (cmd.q_start) begin
         ord_rd_addr = '0;
      end
      ord_wr_en = cmd.reg_shift || cmd.insert;
      if (cmd.reg_shift) begin
         ord_wr_addr = walk_ff + ID_W'(1);
         ord_wr_data = ord_rd_data;
      end else begin
         ord_wr_addr      = pos_ff;
         ord_wr_data.prio = pr_ff;
         ord_wr_data.id   = count_id;
      end
   end

   always_comb begin
      ev_rd_en   = cmd.ev_rd_tid || (cmd.q_step && a_valid_ff);
      ev_rd_addr = cmd.ev_rd_tid ? tid_idx : ord_rd_data.id;
      ev_wr_en   = cmd.ev_update || cmd.insert;
      ev_wr_addr = cmd.insert ? count_id : tid_idx;
      ev_wr_data = cmd.insert ? '0 : new_mask;
   end

   always_comb begin
      res_in = res_ff;
      if (cmd.res_full) begin
         res_in = '{status: STAT_FULL, id: '0, found: 1'b0, mask: '0};
      end else if (cmd.res_invalid) begin
         res_in = '{status: STAT_INVALID, id: tid_ff, found: 1'b0, mask: '0};
      end else if (cmd.res_none) begin
         res_in = '{status: STAT_OK, id: '0, found: 1'b0, mask: '0};
      end else if (cmd.res_found) begin
         res_in = '{status: STAT_OK, id: to_rsp_id(hit_id_ff), found: 1'b1, mask: ev_rd_data};
      end else if (cmd.insert) begin
         res_in = '{status: STAT_OK, id: to_rsp_id(count_id), found: 1'b0, mask: '0};
      end else if (cmd.ev_update) begin
         res_in = '{status: STAT_OK, id: tid_ff, found: 1'b0, mask: new_mask};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (cmd.insert) begin
            count_ff <= count_ff + COUNT_W'(1);
         end
         if (cmd.q_start) begin
            a_valid_ff <= 1'b1;
            b_valid_ff <= 1'b0;
         end else if (cmd.q_step) begin
            a_valid_ff <= more;
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= op_type'(req_opcode);
         tid_ff   <= req_task_id;
         flags_ff <= req_flags;
         pr_ff    <= pr_ext[PRIORITY_BITS-1:0];
      end
      if (cmd.reg_rd_last) begin
         walk_ff <= count_m1[ID_W-1:0];
      end else if (cmd.reg_rd_prev) begin
         walk_ff <= walk_ff - ID_W'(1);
      end
      if (cmd.pos_zero) begin
         pos_ff <= '0;
      end else if (cmd.pos_next) begin
         pos_ff <= walk_ff + ID_W'(1);
      end
      if (cmd.q_start) begin
         next_ff <= COUNT_W'(1);
      end else if (cmd.q_step && more) begin
         next_ff <= next_ff + COUNT_W'(1);
      end
      if (cmd.q_step && a_valid_ff) begin
         hit_id_ff <= ord_rd_data.id;
      end
      res_ff <= res_in;
      if (cmd.load_rsp) begin
         rsp_ff <= res_ff;
      end
   end

   tep_ram #(
      .WIDTH ($bits(order_entry_type)),
      .DEPTH (MAX_TASKS)
   ) u_order_ram (
      .clock   (clock),
      .wr_en   (ord_wr_en),
      .wr_addr (ord_wr_addr),
      .wr_data (ord_wr_data),
      .rd_en   (ord_rd_en),
      .rd_addr (ord_rd_addr),
      .rd_data (ord_rd_data)
   );

   tep_ram #(
      .WIDTH (FLAG_W),
      .DEPTH (MAX_TASKS)
   ) u_event_ram (
      .clock   (clock),
      .wr_en   (ev_wr_en),
      .wr_addr (ev_wr_addr),
      .wr_data (ev_wr_data),
      .rd_en   (ev_rd_en),
      .rd_addr (ev_rd_addr),
      .rd_data (ev_rd_data)
   );

   assign rsp_status     = rsp_ff.status;
   assign rsp_result_id  = rsp_ff.id;
   assign rsp_found      = rsp_ff.found;
   assign rsp_event_mask = rsp_ff.mask;

endmodule

// ===== rtl/core/task_event_priority_scheduler.sv =====
// Top level of the priority ordered event flag task scheduler.
//
//   Channel   Direction   Handshake              Payload
//   req_      in          req_valid / req_stall  opcode, task_id, flags, priority_req
//   rsp_      out         rsp_valid / rsp_stall  status, result_id, found, event_mask
//
// A transaction is taken only while the controller is idle and yields exactly one response.
// Register and query walk the order list RAM, one entry per cycle, so their time can grow with
// the task count; set, clear, a register on a full table and a query of an empty one do not walk.
// Reset is synchronous and active high and empties the table, as the RAMs are read only below
// the task count. A stalled response holds the output register while the next one is worked.
module task_event_priority_scheduler (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tep_pkg::OP_W-1:0]       req_opcode,
   input  logic [tep_pkg::TID_W-1:0]      req_task_id,
   input  logic [tep_pkg::FLAG_W-1:0]     req_flags,
   input  logic [tep_pkg::REQ_PRIO_W-1:0] req_priority_req,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tep_pkg::STATUS_W-1:0]   rsp_status,
   output logic [tep_pkg::TID_W-1:0]      rsp_result_id,
   output logic                           rsp_found,
   output logic [tep_pkg::FLAG_W-1:0]     rsp_event_mask
);
   import tep_pkg::*;

   // The controller issues commands; the RAMs and arithmetic sit in the datapath.
   cmd_type  cmd;
   stat_type stat;

   // The controller owns the handshakes and the response valid flag.
   tep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the order list and event RAMs, the task count and the
   // response payload register.
   tep_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_opcode       (req_opcode),
      .req_task_id      (req_task_id),
      .req_flags        (req_flags),
      .req_priority_req (req_priority_req),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_status       (rsp_status),
      .rsp_result_id    (rsp_result_id),
      .rsp_found        (rsp_found),
      .rsp_event_mask   (rsp_event_mask)
   );

endmodule
